@@ hw/rtl/tecu_pkg.sv @@
// Shared types and constants of the tilde escape byte codec.
`timescale 1ns / 1ps
`default_nettype none

package tecu_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] TildeChar = 8'h7E;
  localparam logic [ByteW-1:0] AtChar    = 8'h40;
  localparam logic [ByteW-1:0] PrintLow  = 8'd32;
  localparam logic [ByteW-1:0] PrintHigh = 8'd126;

  // APB register map
  localparam int unsigned PaddrW  = 3;
  localparam logic        RegDirIdx = 1'b0;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_e;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_TILDE  = 2'd1,
    PH_HIGH   = 2'd2
  } phase_e;

  // One classified item: up to three output bytes
  typedef struct packed {
    logic [2:0][ByteW-1:0] bytes;
    logic [1:0]            last_idx;
    logic                  eos;
  } job_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/tecu_in_if.sv @@
// Input byte channel of the codec.
`timescale 1ns / 1ps
`default_nettype none

interface tecu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tecu_out_if.sv @@
// Output byte channel of the codec.
`timescale 1ns / 1ps
`default_nettype none

interface tecu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_last;

  modport source (output valid, output out_byte, output run_last, output string_last,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_last,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tecu_front.sv @@
// Front end: accepts input beats, classifies them and tracks the decode phase.
`timescale 1ns / 1ps
`default_nettype none

module tecu_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tecu_pkg::dir_e dir_i,
  input  wire tecu_pkg::q_stat_t q_stat_i,
  tecu_in_if.sink             in_i,
  output logic                push_o,
  output tecu_pkg::job_t      job_o
);
  import tecu_pkg::*;

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  held_high_q, held_high_d;
  logic              accept;
  logic              emit;
  logic [ByteW-1:0]  b;
  logic [ByteW-1:0]  hi_v, lo_v;

  assign in_i.ready = ~q_stat_i.full;
  assign accept     = in_i.valid & ~q_stat_i.full;
  assign b          = in_i.in_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_NORMAL;
      held_high_q <= '0;
    end else begin
      phase_q     <= phase_d;
      held_high_q <= held_high_d;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    held_high_d  = held_high_q;
    emit         = 1'b0;
    job_o.bytes  = '0;
    job_o.last_idx = 2'd0;
    job_o.eos    = in_i.end_of_string;
    hi_v         = held_high_q - AtChar;
    lo_v         = b - AtChar;

    if (dir_i == DIR_ENCODE) begin
      emit = 1'b1;
      if (b < PrintLow || b > PrintHigh) begin
        job_o.bytes[0] = TildeChar;
        job_o.bytes[1] = {4'b0, b[7:4]} + AtChar;
        job_o.bytes[2] = {4'b0, b[3:0]} + AtChar;
        job_o.last_idx = 2'd2;
      end else if (b == TildeChar) begin
        job_o.bytes[0] = TildeChar;
        job_o.bytes[1] = TildeChar;
        job_o.last_idx = 2'd1;
      end else begin
        job_o.bytes[0] = b;
      end
    end else begin
      case (phase_q)
        PH_TILDE: begin
          if (b == TildeChar || in_i.end_of_string) begin
            emit           = 1'b1;
            job_o.bytes[0] = b;
            phase_d        = PH_NORMAL;
          end else begin
            if (accept) held_high_d = b;
            phase_d = PH_HIGH;
          end
        end
        PH_HIGH: begin
          emit           = 1'b1;
          job_o.bytes[0] = {hi_v[3:0], 4'b0} | lo_v;
          phase_d        = PH_NORMAL;
        end
        default: begin
          if (b == TildeChar) begin
            phase_d = PH_TILDE;
          end else begin
            emit           = 1'b1;
            job_o.bytes[0] = b;
            phase_d        = PH_NORMAL;
          end
        end
      endcase
      // end of string always closes an escape
      if (in_i.end_of_string) phase_d = PH_NORMAL;
    end

    // hold state unless a beat is taken
    if (!accept) phase_d = phase_q;
  end

  assign push_o = accept & emit;

endmodule

`default_nettype wire

@@ hw/rtl/tecu_queue.sv @@
// Two-entry job queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none

module tecu_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire tecu_pkg::job_t  job_i,
  input  wire logic            pop_i,
  output tecu_pkg::job_t       job_o,
  output tecu_pkg::q_stat_t    stat_o
);
  import tecu_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

  assign job_o        = mem_q[rd_ptr_q];
  assign stat_o.full  = cnt_q == 2'd2;
  assign stat_o.empty = cnt_q == 2'd0;

endmodule

`default_nettype wire

@@ hw/rtl/tecu_back.sv @@
// Back end: plays out the bytes of each job, one output beat per cycle while out_o is ready.
`timescale 1ns / 1ps
`default_nettype none

module tecu_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tecu_pkg::job_t    job_i,
  input  wire tecu_pkg::q_stat_t q_stat_i,
  output logic                   pop_o,
  tecu_out_if.source             out_o
);
  import tecu_pkg::*;

  job_t       job_q;
  logic       busy_q, busy_d;
  logic [1:0] idx_q, idx_d;
  logic       last;
  logic       finish;

  assign last   = idx_q == job_q.last_idx;
  assign finish = busy_q & out_o.ready & last;
  assign pop_o  = (~busy_q | finish) & ~q_stat_i.empty;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (pop_o) begin
      busy_d = 1'b1;
      idx_d  = 2'd0;
    end else if (finish) begin
      busy_d = 1'b0;
    end else if (busy_q && out_o.ready) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
  end

  assign out_o.valid       = busy_q;
  assign out_o.out_byte    = job_q.bytes[idx_q];
  assign out_o.run_last    = last;
  assign out_o.string_last = last & job_q.eos;

endmodule

`default_nettype wire

@@ hw/rtl/tilde_escape_byte_codec_unit.sv @@
// Top level of the tilde escape byte codec with its APB register.
//
// Usage: bytes enter on in_i (valid/ready, with an end-of-string flag) and
// leave on out_o (valid/ready), each output beat marked run_last on the last
// byte an input caused and string_last when that input closed the string.
// Register 0 at byte address 0 (codec_direction) selects encode (0) or decode
// (1); write it only while the block is idle. pready is always high.
// Path: a beat accepted on in_i is written into the job queue, the back end
// loads it from there into its job register, and its first byte is offered
// on out_o from that register.
// Throughput: one output byte per cycle while out_o is ready, set by the back
// end that plays out queued jobs; a plain byte passes at one input beat per
// cycle while the queue has room, and an escape of two or three bytes holds
// the input once the two-entry job queue fills. Inputs that produce nothing push no job.
// Receiver stall: the current output beat holds, the queue fills and in_i
// drops ready when it is full.
// Reset clears the direction to encode, the decode phase, the held high byte
// and the queue; no output is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module tilde_escape_byte_codec_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  tecu_in_if.sink                           in_i,
  tecu_out_if.source                        out_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tecu_pkg::PaddrW-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import tecu_pkg::*;

  dir_e    dir_q;
  logic    push;
  logic    pop;
  job_t    push_job;
  job_t    head_job;
  q_stat_t q_stat;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DIR_ENCODE;
    end else if (psel && penable && pwrite && paddr[2] == RegDirIdx) begin
      dir_q <= dir_e'(pwdata[0]);
    end
  end

  assign prdata = (paddr[2] == RegDirIdx) ? {31'b0, dir_q} : 32'b0;

  tecu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .dir_i    (dir_q),
    .q_stat_i (q_stat),
    .in_i     (in_i),
    .push_o   (push),
    .job_o    (push_job)
  );

  tecu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (q_stat)
  );

  tecu_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_i    (head_job),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the tilde escape byte codec unit.
`timescale 1ns / 1ps

module testbench;
  import tecu_pkg::*;

  typedef logic [ByteW-1:0] byte_t;

  typedef struct packed {
    byte_t out_byte;
    logic  run_last;
    logic  string_last;
  } out_beat_t;

  typedef struct packed {
    byte_t in_byte;
    logic  eos;
  } in_beat_t;

  localparam logic [PaddrW-1:0] DirAddr   = PaddrW'({RegDirIdx, 2'b00});
  localparam logic [PaddrW-1:0] SpareAddr = PaddrW'(4);
  localparam int unsigned       CycleLimit = 200000;
  localparam int unsigned       DrainCycles = 8;
  localparam int unsigned       SegmentItems = 14;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tecu_in_if  in_ch();
  tecu_out_if out_ch();

  tilde_escape_byte_codec_unit u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state, mirrored from the block
  dir_e        codec_dir;
  phase_e      dec_phase;
  byte_t       held_high;

  in_beat_t    byte_backlog[$];
  out_beat_t   awaited_beats[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.in_byte       = '0;
    in_ch.end_of_string = 1'b0;
    out_ch.ready        = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Escaped form of one raw byte, first byte in seq[0]
  function automatic int unsigned escape_byte(input byte_t b, output byte_t seq[3]);
    seq[0] = b;
    seq[1] = '0;
    seq[2] = '0;
    if (b < PrintLow || b > PrintHigh) begin
      seq[0] = TildeChar;
      seq[1] = {4'h0, b[7:4]} + AtChar;
      seq[2] = {4'h0, b[3:0]} + AtChar;
      return 3;
    end
    if (b == TildeChar) begin
      seq[1] = TildeChar;
      return 2;
    end
    return 1;
  endfunction

  // Work out the output beats that one accepted input beat causes
  function automatic void predict_codec(input byte_t b, input logic eos);
    byte_t       seq[3];
    int unsigned n;
    phase_e      nxt;
    byte_t       hi;
    byte_t       lo;
    out_beat_t   ob;
    n = 0;
    seq[0] = '0;
    if (codec_dir == DIR_ENCODE) begin
      n = escape_byte(b, seq);
    end else begin
      nxt = PH_NORMAL;
      case (dec_phase)
        PH_TILDE: begin
          if (b == TildeChar || eos) begin
            seq[0] = b;
            n = 1;
          end else begin
            held_high = b;
            nxt = PH_HIGH;
          end
        end
        PH_HIGH: begin
          hi = held_high - AtChar;
          lo = b - AtChar;
          seq[0] = {hi[3:0], 4'h0} | lo;
          n = 1;
        end
        default: begin
          if (b == TildeChar) begin
            nxt = PH_TILDE;
          end else begin
            seq[0] = b;
            n = 1;
          end
        end
      endcase
      // end of string always closes an open escape
      if (eos) nxt = PH_NORMAL;
      dec_phase = nxt;
    end
    for (int unsigned k = 0; k < n; k++) begin
      ob.out_byte    = seq[k];
      ob.run_last    = (k == n - 1);
      ob.string_last = (k == n - 1) && eos;
      awaited_beats.push_back(ob);
    end
  endfunction

  task automatic report_mismatch(input string field, input byte_t got, input byte_t want);
    $display("[%0t] mismatch on %s: got 0x%02h, want 0x%02h", $realtime, field, got, want);
    mismatches++;
  endtask

  // Driver: predict on each accepted beat, then offer the next one
  always @(posedge clk) begin
    in_beat_t nb;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_codec(in_ch.in_byte, in_ch.end_of_string);
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nb = byte_backlog.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.in_byte       <= nb.in_byte;
          in_ch.end_of_string <= nb.eos;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each output beat with the oldest awaited one
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_beats.size() == 0) begin
          report_mismatch("beat with nothing awaited", out_ch.out_byte, '0);
        end else begin
          want = awaited_beats.pop_front();
          if (out_ch.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_ch.out_byte, want.out_byte);
          if (out_ch.run_last !== want.run_last)
            report_mismatch("run_last", byte_t'(out_ch.run_last), byte_t'(want.run_last));
          if (out_ch.string_last !== want.string_last)
            report_mismatch("string_last", byte_t'(out_ch.string_last),
                            byte_t'(want.string_last));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_byte(input byte_t b, input logic eos);
    in_beat_t ib;
    ib.in_byte = b;
    ib.eos     = eos;
    byte_backlog.push_back(ib);
  endtask

  // Hold until every queued beat is in and every awaited beat is out;
  // check on the falling edge so the driver and monitor have settled
  task automatic wait_idle();
    @(negedge clk);
    while (byte_backlog.size() > 0 || in_ch.valid || awaited_beats.size() > 0)
      @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PaddrW-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == DirAddr) codec_dir = dir_e'(data[0]);
  endtask

  task automatic set_direction(input dir_e d);
    wait_idle();
    apb_write(DirAddr, {31'($urandom()), d});
  endtask

  function automatic byte_t pick_raw_byte();
    case ($urandom_range(7))
      0: return TildeChar;
      1: return PrintLow;
      2: return PrintHigh;
      3: return byte_t'(PrintLow - 1);
      4: return byte_t'(PrintHigh + 1);
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  task automatic random_encode_segment();
    for (int unsigned i = 0; i < SegmentItems; i++)
      queue_byte(pick_raw_byte(), $urandom_range(5) == 0);
  endtask

  // Mostly well-formed escaped strings, the rest noise and cut-off escapes
  task automatic random_decode_segment();
    byte_t       seq[3];
    byte_t       str[$];
    int unsigned n;
    int unsigned cut;
    int unsigned count;
    count = 0;
    while (count < SegmentItems) begin
      str.delete();
      if ($urandom_range(99) < 80) begin
        repeat ($urandom_range(4, 1)) begin
          n = escape_byte(pick_raw_byte(), seq);
          for (int unsigned k = 0; k < n; k++) str.push_back(seq[k]);
        end
        // sometimes cut the string short in the middle of an escape
        if ($urandom_range(9) == 0) begin
          cut = $urandom_range(str.size(), 1);
          while (str.size() > cut) void'(str.pop_back());
        end
      end else begin
        repeat ($urandom_range(4, 1))
          str.push_back($urandom_range(2) == 0 ? TildeChar : byte_t'($urandom_range(255)));
      end
      foreach (str[k]) queue_byte(str[k], k == str.size() - 1);
      count += str.size();
    end
  endtask

  initial begin
    int unsigned send_modes[3];
    int unsigned recv_modes[3];
    send_modes = '{11, 81, 0};
    recv_modes = '{81, 11, 0};
    mismatches    = 0;
    cycle_count   = 0;
    codec_dir     = DIR_ENCODE;
    dec_phase     = PH_NORMAL;
    held_high     = '0;
    send_idle_pct = send_modes[0];
    recv_idle_pct = recv_modes[0];
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // encode: range edges, tilde, plain byte closing the string
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(byte_t'(PrintLow - 1), 1'b0);
    queue_byte(PrintLow, 1'b0);
    queue_byte(TildeChar, 1'b0);
    queue_byte(byte_t'(PrintHigh + 1), 1'b0);
    queue_byte(8'h7D, 1'b0);
    queue_byte("A", 1'b1);
    wait_idle();
    apb_write(SpareAddr, 32'hFFFF_FFFF);
    set_direction(DIR_DECODE);

    // decode: tilde pair, escape, escape with no range check, plain end
    queue_byte(TildeChar, 1'b0);
    queue_byte(TildeChar, 1'b0);
    queue_byte(TildeChar, 1'b0);
    queue_byte("A", 1'b0);
    queue_byte("B", 1'b0);
    queue_byte(TildeChar, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte("x", 1'b1);
    // lone tilde at the end gives nothing
    queue_byte(TildeChar, 1'b1);
    // tilde and one byte at the end gives that byte
    queue_byte(TildeChar, 1'b0);
    queue_byte("Z", 1'b1);
    // leave an escape open across a spell of encoding
    queue_byte(TildeChar, 1'b0);
    queue_byte("C", 1'b0);
    set_direction(DIR_ENCODE);
    queue_byte("q", 1'b1);
    set_direction(DIR_DECODE);
    queue_byte("D", 1'b1);
    wait_idle();
    apb_write(SpareAddr, $urandom());

    for (int m = 0; m < 3; m++) begin
      send_idle_pct = send_modes[m];
      recv_idle_pct = recv_modes[m];
      set_direction(DIR_ENCODE);
      random_encode_segment();
      set_direction(DIR_DECODE);
      random_decode_segment();
    end
    wait_idle();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
